FILE: sv/pnve_pkg.sv
// ----------------------------------------------------------------------------
// pnve_pkg: shared types and tables
// Word layouts, register indexes, envelope state and the note period table.
// ----------------------------------------------------------------------------
package pnve_pkg;

	localparam int unsigned NOTE_W   = 7;
	localparam int unsigned PERIOD_W = 11;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned REST_NOTE = 72;

	localparam logic [3:0] NOISE_START_LEVEL = 4'h9;   // 0x90 high nibble
	localparam logic [2:0] NOISE_RELOAD      = 3'h0;   // 0x90 low three bits
	localparam logic [1:0] CTRL_FLAGS        = 2'b11;  // the 0x30 bits

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PLAYING           = 3'd0,
		REG_LEAD_VOLUME       = 3'd1,
		REG_LEAD_INSTRUMENT   = 3'd2,
		REG_SECOND_VOLUME     = 3'd3,
		REG_SECOND_INSTRUMENT = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic                lead_trigger;
		logic [NOTE_W-1:0]   lead_note;
		logic                lead_effect_busy;
		logic                second_trigger;
		logic [NOTE_W-1:0]   second_note;
		logic                noise_trigger;
		logic [7:0]          noise_word;
		logic                noise_effect_busy;
	} in_word_t;

	typedef struct packed {
		logic [7:0]          lead_control;
		logic [PERIOD_W-1:0] lead_period;
		logic                lead_key_on;
		logic [7:0]          second_control;
		logic [PERIOD_W-1:0] second_period;
		logic                second_key_on;
		logic [5:0]          noise_control;
		logic [7:0]          noise_mode;
		logic                noise_key_on;
	} out_word_t;

	typedef struct packed {
		logic [2:0] timer;
		logic [3:0] level;
	} env_t;

	localparam logic [PERIOD_W-1:0] PERIOD_TABLE [0:REST_NOTE] = '{
		11'h7f1,11'h77f,11'h713,11'h6ad,11'h64d,11'h5f3,11'h59d,11'h54c,
		11'h500,11'h4b8,11'h474,11'h434,11'h3f8,11'h3bf,11'h389,11'h356,
		11'h326,11'h2f9,11'h2ce,11'h2a6,11'h280,11'h25c,11'h23a,11'h21a,
		11'h1fb,11'h1df,11'h1c4,11'h1ab,11'h193,11'h17c,11'h167,11'h152,
		11'h13f,11'h12d,11'h11c,11'h10c,11'h0fd,11'h0ef,11'h0e1,11'h0d5,
		11'h0c9,11'h0bd,11'h0b3,11'h0a9,11'h09f,11'h096,11'h08e,11'h086,
		11'h07e,11'h077,11'h070,11'h06a,11'h064,11'h05e,11'h059,11'h054,
		11'h04f,11'h04b,11'h046,11'h042,11'h03f,11'h03b,11'h038,11'h034,
		11'h031,11'h02f,11'h02c,11'h029,11'h027,11'h025,11'h023,11'h021,
		11'h000
	};

	// indexes above the rest entry saturate to the rest entry
	function automatic logic [PERIOD_W-1:0] period_lookup(input logic [NOTE_W-1:0] note);
		logic [PERIOD_W-1:0] p;
		if (note > NOTE_W'(REST_NOTE)) begin
			p = PERIOD_TABLE[REST_NOTE];
		end else begin
			p = PERIOD_TABLE[note];
		end
		return p;
	endfunction

endpackage

FILE: sv/pnve_env.sv
// ----------------------------------------------------------------------------
// pnve_env: one volume envelope step
// Counts the envelope timer down; on expiry reloads it and drops the level.
// ----------------------------------------------------------------------------
module pnve_env (
	input  pnve_pkg::env_t cur,
	input  logic [2:0]     reload,
	output pnve_pkg::env_t nxt
);
	import pnve_pkg::*;

	logic [2:0] dec;

	assign dec = cur.timer - 3'd1;

	always_comb begin
		nxt = cur;
		if (cur.timer != 3'd0) begin
			nxt.timer = dec;
			if (dec == 3'd0) begin
				nxt.timer = reload;
				if (cur.level != 4'd0) begin
					nxt.level = cur.level - 4'd1;
				end
			end
		end
	end

endmodule

FILE: sv/pulse_noise_volume_envelope.sv
// ----------------------------------------------------------------------------
// pulse_noise_volume_envelope: pulse and noise envelope tick
// Note triggers, envelopes and length counters for two pulse voices and noise.
// ----------------------------------------------------------------------------
// usage
//  - in channel (in_valid/in_ready/in_word): one word per tick carrying the
//    optional note triggers for lead, second and noise voices
//  - out channel (out_valid/out_ready/out_word): one word per tick with the
//    control bytes, held periods and key-on flags after the tick
//  - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//    always ready; unknown indexes are dropped; write only while idle
//  - result: registered, and shows in the cycle after its input word is taken
//  - throughput: one word per cycle unless a result stalls; a tick's work
//    is a short path from voice state and incoming word to the result register
//  - the period lookup is a constant table read in the same cycle
//  - stall: in_ready follows out_ready while a result waits, so a new word
//    is taken in the very cycle the pending result leaves
//  - reset: every voice state, config register and the result valid clear at once
// ----------------------------------------------------------------------------
module pulse_noise_volume_envelope (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  pnve_pkg::in_word_t                  in_word,
	output logic                                out_valid,
	input  logic                                out_ready,
	output pnve_pkg::out_word_t                 out_word,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pnve_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [7:0]                          cfg_data
);
	import pnve_pkg::*;

	// configuration registers
	logic       playing_q;
	logic [7:0] lead_volume_q, lead_instrument_q;
	logic [7:0] second_volume_q, second_instrument_q;

	// voice state
	env_t                lead_env_q, second_env_q, noise_env_q;
	logic [7:0]          lead_latched_q;
	logic [3:0]          lead_ctrl_high_q;
	logic [3:0]          lead_length_q;
	logic [2:0]          second_length_q;
	logic [PERIOD_W-1:0] lead_period_q, second_period_q;
	logic [7:0]          noise_mode_q;

	// result register
	logic      out_valid_q;
	out_word_t out_word_q;

	logic accept;

	// event stage signals
	logic                lead_fire, second_fire, noise_fire;
	logic [PERIOD_W-1:0] lead_p, second_p;
	logic                lead_on, second_on, noise_on;
	env_t                lead_ev, second_ev, noise_ev;
	env_t                lead_st, second_st, noise_st;
	logic [7:0]          lead_latched_d;
	logic [3:0]          lead_ctrl_high_d;
	logic [3:0]          lead_length_ev, lead_length_d;
	logic [2:0]          second_length_ev, second_length_d;
	logic [PERIOD_W-1:0] lead_period_d, second_period_d;
	logic [7:0]          noise_mode_d;
	logic [3:0]          lead_level_d, second_level_d;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q           <= 1'b0;
			lead_volume_q       <= '0;
			lead_instrument_q   <= '0;
			second_volume_q     <= '0;
			second_instrument_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PLAYING:           playing_q           <= cfg_data[0];
				REG_LEAD_VOLUME:       lead_volume_q       <= cfg_data;
				REG_LEAD_INSTRUMENT:   lead_instrument_q   <= cfg_data;
				REG_SECOND_VOLUME:     second_volume_q     <= cfg_data;
				REG_SECOND_INSTRUMENT: second_instrument_q <= cfg_data;
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	// note events; a sound effect blocks lead and noise but never second
	assign lead_fire   = playing_q && in_word.lead_trigger && !in_word.lead_effect_busy;
	assign second_fire = playing_q && in_word.second_trigger;
	assign noise_fire  = playing_q && in_word.noise_trigger && !in_word.noise_effect_busy;

	assign lead_p   = period_lookup(in_word.lead_note);
	assign second_p = period_lookup(in_word.second_note);

	assign lead_on   = lead_fire && (lead_p != '0);
	assign second_on = second_fire && (second_p != '0);
	assign noise_on  = noise_fire && (in_word.noise_word != 8'd0);

	always_comb begin
		// lead voice
		lead_ev          = lead_env_q;
		lead_latched_d   = lead_latched_q;
		lead_ctrl_high_d = lead_ctrl_high_q;
		lead_period_d    = lead_period_q;
		lead_length_ev   = lead_length_q;
		if (lead_on) begin
			lead_ev.level    = lead_volume_q[7:4];
			lead_ev.timer    = lead_volume_q[2:0];
			lead_latched_d   = lead_volume_q;
			lead_ctrl_high_d = {lead_instrument_q[7:6], CTRL_FLAGS};
			lead_period_d    = lead_p;
			lead_length_ev   = lead_instrument_q[5:2];
		end else if (lead_fire) begin
			lead_ev.level = 4'd0;  // rest
		end

		// second voice
		second_ev        = second_env_q;
		second_period_d  = second_period_q;
		second_length_ev = second_length_q;
		if (second_on) begin
			second_ev.level  = second_volume_q[7:4];
			second_ev.timer  = second_volume_q[2:0];
			second_period_d  = second_p;
			second_length_ev = second_instrument_q[5:3];
		end else if (second_fire) begin
			second_ev.level = 4'd0;
		end

		// noise voice
		noise_ev     = noise_env_q;
		noise_mode_d = noise_mode_q;
		if (noise_on) begin
			noise_ev.level = NOISE_START_LEVEL;
			noise_ev.timer = NOISE_RELOAD;
			noise_mode_d   = in_word.noise_word;
		end else if (noise_fire) begin
			noise_ev.level = 4'd0;
		end
	end

	pnve_env u_lead_env (
		.cur    (lead_ev),
		.reload (lead_latched_d[2:0]),
		.nxt    (lead_st)
	);

	pnve_env u_second_env (
		.cur    (second_ev),
		.reload (second_volume_q[2:0]),
		.nxt    (second_st)
	);

	pnve_env u_noise_env (
		.cur    (noise_ev),
		.reload (NOISE_RELOAD),
		.nxt    (noise_st)
	);

	// length counters; running out restores the start level
	always_comb begin
		lead_length_d = lead_length_ev;
		lead_level_d  = lead_st.level;
		if (lead_length_ev != 4'd0) begin
			lead_length_d = lead_length_ev - 4'd1;
			if (lead_length_d == 4'd0) begin
				lead_level_d = lead_latched_d[7:4];
			end
		end

		second_length_d = second_length_ev;
		second_level_d  = second_st.level;
		if (second_length_ev != 3'd0) begin
			second_length_d = second_length_ev - 3'd1;
			if (second_length_d == 3'd0) begin
				second_level_d = second_volume_q[7:4];
			end
		end
	end

	// voice state advances once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_env_q       <= '0;
			second_env_q     <= '0;
			noise_env_q      <= '0;
			lead_latched_q   <= '0;
			lead_ctrl_high_q <= '0;
			lead_length_q    <= '0;
			second_length_q  <= '0;
			lead_period_q    <= '0;
			second_period_q  <= '0;
			noise_mode_q     <= '0;
		end else if (accept) begin
			lead_env_q       <= '{timer: lead_st.timer, level: lead_level_d};
			second_env_q     <= '{timer: second_st.timer, level: second_level_d};
			noise_env_q      <= noise_st;
			lead_latched_q   <= lead_latched_d;
			lead_ctrl_high_q <= lead_ctrl_high_d;
			lead_length_q    <= lead_length_d;
			second_length_q  <= second_length_d;
			lead_period_q    <= lead_period_d;
			second_period_q  <= second_period_d;
			noise_mode_q     <= noise_mode_d;
		end
	end

	// result word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			out_word_q.lead_control   <= {lead_ctrl_high_d, lead_level_d};
			out_word_q.lead_period    <= lead_period_d;
			out_word_q.lead_key_on    <= lead_on;
			out_word_q.second_control <= {second_instrument_q[7:6], CTRL_FLAGS, second_level_d};
			out_word_q.second_period  <= second_period_d;
			out_word_q.second_key_on  <= second_on;
			out_word_q.noise_control  <= {CTRL_FLAGS, noise_st.level};
			out_word_q.noise_mode     <= noise_mode_d;
			out_word_q.noise_key_on   <= noise_on;
		end
	end

endmodule

FILE: sv/pnve_chk.sv
// ----------------------------------------------------------------------------
// pnve_chk: port checker
// Watches the result channel of the envelope block over time.
// ----------------------------------------------------------------------------
module pnve_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input pnve_pkg::out_word_t out_word
);
	import pnve_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	// a result appears only after an input word was taken
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result without an accepted input word");

	// a started pulse note always carries a real period
	a_lead_period: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.lead_key_on |-> out_word.lead_period != '0)
		else $error("lead key-on with zero period");

	a_second_period: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.second_key_on |-> out_word.second_period != '0)
		else $error("second key-on with zero period");

	// a started noise event never holds the rest word
	a_noise_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.noise_key_on |-> out_word.noise_mode != 8'd0)
		else $error("noise key-on with rest word");

endmodule

bind pulse_noise_volume_envelope pnve_chk u_pnve_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: pulse_noise_volume_envelope testbench
// Drives note ticks through the in channel with random gaps, stalls the out
// channel at random and checks every result word against a cycle-free model
// of the voices kept here. Registers are set between phases while the block
// is idle; phases cover reset values, extremes and random settings.
// ----------------------------------------------------------------------------
module tb_top;
	import pnve_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 500000;
	localparam int unsigned SETTLE_CYCLES = 4;      // result shows in the cycle after its word
	localparam int unsigned PHASE_TICKS   = 150;
	localparam int unsigned REPORT_CAP    = 40;     // keep the log short on a broken block
	localparam logic [2:0]  REG_COUNT     = 3'd5;   // first index with no register behind it
	localparam logic [6:0]  REST_IDX      = 7'd72;
	localparam logic [3:0]  NOISE_ATTACK  = 4'h9;
	localparam logic [2:0]  NOISE_RELOAD  = 3'd0;

	// timer periods per note; the last entry is the rest
	localparam logic [10:0] NOTE_PERIOD [0:72] = '{
		11'h7f1, 11'h77f, 11'h713, 11'h6ad, 11'h64d, 11'h5f3, 11'h59d, 11'h54c,
		11'h500, 11'h4b8, 11'h474, 11'h434, 11'h3f8, 11'h3bf, 11'h389, 11'h356,
		11'h326, 11'h2f9, 11'h2ce, 11'h2a6, 11'h280, 11'h25c, 11'h23a, 11'h21a,
		11'h1fb, 11'h1df, 11'h1c4, 11'h1ab, 11'h193, 11'h17c, 11'h167, 11'h152,
		11'h13f, 11'h12d, 11'h11c, 11'h10c, 11'h0fd, 11'h0ef, 11'h0e1, 11'h0d5,
		11'h0c9, 11'h0bd, 11'h0b3, 11'h0a9, 11'h09f, 11'h096, 11'h08e, 11'h086,
		11'h07e, 11'h077, 11'h070, 11'h06a, 11'h064, 11'h05e, 11'h059, 11'h054,
		11'h04f, 11'h04b, 11'h046, 11'h042, 11'h03f, 11'h03b, 11'h038, 11'h034,
		11'h031, 11'h02f, 11'h02c, 11'h029, 11'h027, 11'h025, 11'h023, 11'h021,
		11'h000
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_word_t    in_word = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_word_t   out_word;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	// register copies as the block should hold them
	logic        play_en;
	logic [7:0]  lead_vol_r, lead_instr_r, sec_vol_r, sec_instr_r;

	// voice state mirror
	logic [3:0]  lead_lvl, sec_lvl, noise_lvl;
	logic [2:0]  lead_tmr, sec_tmr, noise_tmr;
	logic [7:0]  lead_latched;
	logic [3:0]  lead_hi;
	logic [3:0]  lead_len;
	logic [2:0]  sec_len;
	logic [10:0] lead_per, sec_per;
	logic [7:0]  noise_held;

	in_word_t    ticks_to_send[$];
	out_word_t   tick_results_due[$];

	int unsigned queued_count = 0;
	int unsigned taken_count = 0;
	int unsigned checked_count = 0;
	int unsigned key_on_count = 0;
	int unsigned reg_writes = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	bit          in_taken = 1'b0;
	bit          in_calm = 1'b0;
	bit          out_calm = 1'b0;
	int unsigned in_gap = 0;
	int unsigned out_hold = 0;

	pulse_noise_volume_envelope uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// voice model
	// ------------------------------------------------------------------

	// notes past the rest entry fold onto the rest
	function automatic logic [10:0] note_period(input logic [6:0] note);
		logic [6:0] idx;
		idx = (note > REST_IDX) ? REST_IDX : note;
		return NOTE_PERIOD[idx];
	endfunction

	// one envelope step: an idle timer (zero) never decays the level
	task automatic run_decay(inout logic [2:0] tmr, inout logic [3:0] lvl,
			input logic [2:0] reload);
		if (tmr != 3'd0) begin
			tmr = tmr - 3'd1;
			if (tmr == 3'd0) begin
				tmr = reload;
				if (lvl != 4'd0) begin
					lvl = lvl - 4'd1;
				end
			end
		end
	endtask

	// one tick: note events first, then envelopes, then length counters
	task automatic advance_tick(input in_word_t w, output out_word_t r);
		logic [10:0] p;
		r = '0;
		if (play_en) begin
			// lead voice, blocked while an effect owns it
			if (w.lead_trigger && !w.lead_effect_busy) begin
				p = note_period(w.lead_note);
				if (p == 11'd0) begin
					lead_lvl = 4'd0;
				end else begin
					lead_lvl     = lead_vol_r[7:4];
					lead_tmr     = lead_vol_r[2:0];
					lead_latched = lead_vol_r;
					lead_hi      = {lead_instr_r[7:6], 2'b11};
					lead_per     = p;
					lead_len     = lead_instr_r[5:2];
					r.lead_key_on = 1'b1;
				end
			end
			// second voice has no effect guard at all
			if (w.second_trigger) begin
				p = note_period(w.second_note);
				if (p == 11'd0) begin
					sec_lvl = 4'd0;
				end else begin
					sec_lvl = sec_vol_r[7:4];
					sec_tmr = sec_vol_r[2:0];
					sec_per = p;
					sec_len = sec_instr_r[5:3];
					r.second_key_on = 1'b1;
				end
			end
			// noise: a zero word is a rest
			if (w.noise_trigger && !w.noise_effect_busy) begin
				if (w.noise_word == 8'd0) begin
					noise_lvl = 4'd0;
				end else begin
					noise_lvl  = NOISE_ATTACK;
					noise_tmr  = NOISE_RELOAD;
					noise_held = w.noise_word;
					r.noise_key_on = 1'b1;
				end
			end
		end

		// second voice reloads from the live register, lead from its latch
		run_decay(lead_tmr, lead_lvl, lead_latched[2:0]);
		run_decay(sec_tmr, sec_lvl, sec_vol_r[2:0]);
		run_decay(noise_tmr, noise_lvl, NOISE_RELOAD);

		// length expiry puts the start level back
		if (lead_len != 4'd0) begin
			lead_len = lead_len - 4'd1;
			if (lead_len == 4'd0) begin
				lead_lvl = lead_latched[7:4];
			end
		end
		if (sec_len != 3'd0) begin
			sec_len = sec_len - 3'd1;
			if (sec_len == 3'd0) begin
				sec_lvl = sec_vol_r[7:4];
			end
		end

		r.lead_control   = {lead_hi, lead_lvl};
		r.lead_period    = lead_per;
		r.second_control = {sec_instr_r[7:6], 2'b11, sec_lvl};
		r.second_period  = sec_per;
		r.noise_control  = {2'b11, noise_lvl};
		r.noise_mode     = noise_held;
	endtask

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------

	function automatic void flag_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= REPORT_CAP) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			end
		end
	endfunction

	function automatic void compare_result(input out_word_t want, input out_word_t got);
		flag_field("lead_control", 32'(want.lead_control), 32'(got.lead_control));
		flag_field("lead_period", 32'(want.lead_period), 32'(got.lead_period));
		flag_field("lead_key_on", 32'(want.lead_key_on), 32'(got.lead_key_on));
		flag_field("second_control", 32'(want.second_control), 32'(got.second_control));
		flag_field("second_period", 32'(want.second_period), 32'(got.second_period));
		flag_field("second_key_on", 32'(want.second_key_on), 32'(got.second_key_on));
		flag_field("noise_control", 32'(want.noise_control), 32'(got.noise_control));
		flag_field("noise_mode", 32'(want.noise_mode), 32'(got.noise_mode));
		flag_field("noise_key_on", 32'(want.noise_key_on), 32'(got.noise_key_on));
	endfunction

	// mostly short gaps, a few long ones, none at all while calm
	function automatic int unsigned gap_len(input bit calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 30);
	endfunction

	// ------------------------------------------------------------------
	// driver: presents queued words at the falling edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0) begin
			in_calm = !in_calm;
		end
		// a word stays up, unchanged, until it is taken
		if (!in_valid || in_taken) begin
			if (in_gap != 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (ticks_to_send.size() != 0) begin
				in_word  <= ticks_to_send.pop_front();
				in_valid <= 1'b1;
				in_gap = gap_len(in_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side back-pressure, independent of out_valid
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0) begin
			out_calm = !out_calm;
		end
		if (out_hold != 0) begin
			out_hold--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			out_hold = gap_len(out_calm);
		end
	end

	// ------------------------------------------------------------------
	// monitor: handshakes seen at the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		out_word_t want;
		in_taken = arst_n && in_valid && in_ready;
		if (arst_n) begin
			// a result never leaves in the cycle its word enters, so check first
			if (out_valid && out_ready) begin
				if (tick_results_due.size() == 0) begin
					mismatches++;
					$error("result word with nothing expected");
				end else begin
					compare_result(tick_results_due.pop_front(), out_word);
					checked_count++;
					key_on_count += 32'(out_word.lead_key_on) + 32'(out_word.second_key_on)
						+ 32'(out_word.noise_key_on);
				end
			end
			if (in_taken) begin
				advance_tick(in_word, want);
				tick_results_due.push_back(want);
				taken_count++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				tick_results_due.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------

	function automatic in_word_t make_tick(input bit lt, input logic [6:0] ln, input bit lb,
			input bit st, input logic [6:0] sn, input bit nt, input logic [7:0] nw,
			input bit nb);
		in_word_t w;
		w.lead_trigger      = lt;
		w.lead_note         = ln;
		w.lead_effect_busy  = lb;
		w.second_trigger    = st;
		w.second_note       = sn;
		w.noise_trigger     = nt;
		w.noise_word        = nw;
		w.noise_effect_busy = nb;
		return w;
	endfunction

	task automatic push_tick(input in_word_t w);
		ticks_to_send.push_back(w);
		queued_count++;
	endtask

	// notes mostly playable, some rests and some past the table end
	function automatic logic [6:0] pick_note();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			return 7'($urandom_range(0, 71));
		end else if (r < 90) begin
			return REST_IDX;
		end
		return 7'($urandom_range(73, 127));
	endfunction

	task automatic queue_random(input int unsigned n);
		logic [7:0] nw;
		repeat (n) begin
			nw = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(1, 255)) : 8'd0;
			push_tick(make_tick($urandom_range(0, 99) < 40, pick_note(),
				$urandom_range(0, 99) < 15, $urandom_range(0, 99) < 40, pick_note(),
				$urandom_range(0, 99) < 30, nw, $urandom_range(0, 99) < 15));
		end
	endtask

	// wait until every queued word is in and its result checked
	task automatic wait_idle();
		do @(negedge clk);
		while (taken_count != queued_count || tick_results_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// valid is held across back-to-back writes and dropped by the caller
	task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_PLAYING:           play_en = data[0];
			REG_LEAD_VOLUME:       lead_vol_r = data;
			REG_LEAD_INSTRUMENT:   lead_instr_r = data;
			REG_SECOND_VOLUME:     sec_vol_r = data;
			REG_SECOND_INSTRUMENT: sec_instr_r = data;
			default: ;
		endcase
		reg_writes++;
	endtask

	// full register set plus one write to an index with no register
	task automatic program_voices(input logic [7:0] play, input logic [7:0] lv,
			input logic [7:0] li, input logic [7:0] sv, input logic [7:0] si);
		write_reg(REG_SECOND_INSTRUMENT, si);
		write_reg(REG_COUNT + 3'($urandom_range(0, 2)), 8'($urandom));
		write_reg(REG_LEAD_VOLUME, lv);
		write_reg(REG_PLAYING, play);
		write_reg(REG_SECOND_VOLUME, sv);
		write_reg(REG_LEAD_INSTRUMENT, li);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		play_en = 1'b0;
		lead_vol_r = '0; lead_instr_r = '0; sec_vol_r = '0; sec_instr_r = '0;
		lead_lvl = '0; sec_lvl = '0; noise_lvl = '0;
		lead_tmr = '0; sec_tmr = '0; noise_tmr = '0;
		lead_latched = '0; lead_hi = '0; lead_len = '0; sec_len = '0;
		lead_per = '0; sec_per = '0; noise_held = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset registers: music off, every trigger must be dropped
		@(posedge clk);
		queue_random(8);
		wait_idle();

		// directed: fast lead decay, long lead length, short second length
		program_voices(8'h01, 8'hF1, 8'hFF, 8'hA2, 8'hC8);
		@(posedge clk);
		push_tick(make_tick(1, 7'd0, 0, 1, 7'd0, 1, 8'hFF, 0));     // lowest notes
		push_tick(make_tick(0, 7'd0, 0, 0, 7'd0, 0, 8'h00, 0));
		push_tick(make_tick(1, 7'd71, 0, 1, 7'd71, 1, 8'h01, 0));   // highest notes
		push_tick(make_tick(1, REST_IDX, 0, 1, REST_IDX, 1, 8'h00, 0)); // all rests
		push_tick(make_tick(1, 7'd127, 0, 1, 7'd73, 0, 8'h00, 0));  // past the table end
		push_tick(make_tick(1, 7'd64, 1, 1, 7'd50, 1, 8'h80, 1));   // effects own lead, noise
		push_tick(make_tick(1, 7'd5, 0, 0, 7'd0, 1, 8'h00, 1));     // busy noise rest skipped
		repeat (6) push_tick(make_tick(0, 7'd0, 0, 0, 7'd0, 0, 8'h00, 0));
		push_tick(make_tick(1, 7'd36, 1, 1, 7'd100, 1, 8'h7F, 0));
		push_tick(make_tick(1, 7'd85, 0, 1, 7'd64, 1, 8'hAA, 0));
		push_tick(make_tick(0, 7'd0, 0, 1, 7'd33, 1, 8'h55, 0));
		repeat (6) push_tick(make_tick(0, 7'd0, 0, 0, 7'd0, 0, 8'h00, 0));
		push_tick(make_tick(1, 7'd72, 1, 0, 7'd0, 1, 8'h00, 0));   // busy lead rest skipped
		wait_idle();

		// extremes, then random settings, one of them with music off
		program_voices(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		@(posedge clk);
		queue_random(PHASE_TICKS);
		wait_idle();

		program_voices(8'hFE, 8'h00, 8'h00, 8'h00, 8'h00);
		@(posedge clk);
		queue_random(PHASE_TICKS);
		wait_idle();

		for (int i = 0; i < 6; i++) begin
			program_voices((i == 3) ? 8'h00 : 8'($urandom) | 8'h01, 8'($urandom),
				8'($urandom), 8'($urandom), 8'($urandom));
			@(posedge clk);
			queue_random(PHASE_TICKS);
			wait_idle();
		end

		if (tick_results_due.size() != 0) begin
			mismatches++;
			$error("%0d expected results never arrived", tick_results_due.size());
		end

		$display("ran %0d ticks over %0d register writes; %0d results checked",
			taken_count, reg_writes, checked_count);
		$display("%0d key-on flags seen, %0d field mismatches", key_on_count, mismatches);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/pnve_pkg.sv
sv/pnve_env.sv
sv/pulse_noise_volume_envelope.sv
sv/pnve_chk.sv
sim/tb_top.sv
